[src/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SDI_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted (active low).
`define SDI_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[src/sdi_pkg.sv]
package sdi_pkg;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;
    localparam int BLK_LEN_W  = 12;
    localparam int OP_LIM_W   = 10;
    localparam int RST_LIM_W  = 6;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_LIMIT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LIMIT  = 2'd2;

    localparam logic [BLK_LEN_W-1:0] BLK_LEN_RESET   = 12'd512;
    localparam logic [OP_LIM_W-1:0]  OP_LIMIT_RESET  = 10'd500;
    localparam logic [RST_LIM_W-1:0] RST_LIMIT_RESET = 6'd30;

    // Polls after a frame before a response is declared missing, and wake bytes.
    localparam logic [7:0] RESP_WAIT_BYTES = 8'd128;
    localparam logic [4:0] WAKE_BYTES      = 5'd20;

    localparam logic [6:0] CRC7_POLY = 7'h09;

    typedef struct packed {
        logic [BLK_LEN_W-1:0] block_length;
        logic [OP_LIM_W-1:0]  op_limit;
        logic [RST_LIM_W-1:0] reset_limit;
    } t_cfg;

    typedef struct packed {
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       single_clock;
        logic       fast_clock;
        logic       busy;
        logic       done;
        logic       init_ok;
        logic       card_kind;
        logic [2:0] error_code;
    } t_result;

    // One byte through the CRC7 register, most significant bit first.
    function automatic logic [6:0] crc7_feed(input logic [6:0] c, input logic [7:0] b);
        logic [6:0] cc;
        logic [7:0] bb;
        logic       fb;
        cc = c;
        bb = b;
        for (int i = 0; i < 8; i++) begin
            fb = bb[7] ^ cc[6];
            cc = {cc[5:0], 1'b0};
            if (fb) begin
                cc = cc ^ CRC7_POLY;
            end
            bb = {bb[6:0], 1'b0};
        end
        return cc;
    endfunction

endpackage

[src/sdi_seq.sv]
module sdi_seq #(
    parameter logic [7:0] RESP_POLLS = sdi_pkg::RESP_WAIT_BYTES,
    parameter logic [4:0] WAKE_COUNT = sdi_pkg::WAKE_BYTES
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic             i_req_type,
    input  logic [7:0]       i_rx_byte,
    input  sdi_pkg::t_cfg    i_cfg,
    output sdi_pkg::t_result o_res
);
    import sdi_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAKE, PH_CLOCK, PH_FRAME, PH_RESP
    } t_phase;

    localparam logic [5:0] CMD_GO_IDLE    = 6'd0;
    localparam logic [5:0] CMD_SEND_OP    = 6'd1;
    localparam logic [5:0] CMD_SET_BLKLEN = 6'd16;
    localparam logic [5:0] CMD_SD_OP      = 6'd41;
    localparam logic [5:0] CMD_APP        = 6'd55;
    localparam logic [5:0] CMD_CRC_OFF    = 6'd59;

    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_RESET   = 3'd1;
    localparam logic [2:0] ERR_PROBE   = 3'd2;
    localparam logic [2:0] ERR_OP_COND = 3'd3;
    localparam logic [2:0] ERR_BLKLEN  = 3'd4;
    localparam logic [2:0] ERR_CRC_OFF = 3'd5;

    localparam logic [31:0] HCS_ARG = 32'h0020_0000;
    localparam logic [7:0]  R1_IDLE = 8'h01;
    localparam logic [7:0]  IDLE_BYTE = 8'hFF;

    t_phase      r_phase, n_phase;
    logic [2:0]  r_frame_pos, n_frame_pos;
    logic [7:0]  r_wait, n_wait;
    logic [5:0]  r_reset_tries, n_reset_tries;
    logic [9:0]  r_op_tries, n_op_tries;
    logic [4:0]  r_wake, n_wake;
    logic        r_is_sd, n_is_sd;
    logic        r_first, n_first;
    logic        r_app, n_app;
    logic [5:0]  r_cmd, n_cmd;
    logic [31:0] r_arg, n_arg;
    logic [6:0]  r_crc, n_crc;
    logic        r_fast, n_fast;
    t_result     r_res, n_res;

    // Deferred actions, resolved after the main decode in a fixed order.
    logic        do_attempt, do_op_resp, do_start, do_finish, do_clock, do_send;
    logic [5:0]  st_idx;
    logic [31:0] st_arg;
    logic        st_app;
    logic        fin_ok;
    logic [2:0]  fin_err;
    logic [7:0]  send_val;
    logic [2:0]  fp_inc;
    logic [7:0]  frame_byte;

    always_comb begin
        n_phase       = r_phase;
        n_frame_pos   = r_frame_pos;
        n_wait        = r_wait;
        n_reset_tries = r_reset_tries;
        n_op_tries    = r_op_tries;
        n_wake        = r_wake;
        n_is_sd       = r_is_sd;
        n_first       = r_first;
        n_app         = r_app;
        n_cmd         = r_cmd;
        n_arg         = r_arg;
        n_crc         = r_crc;
        n_fast        = r_fast;
        do_attempt    = 1'b0;
        do_op_resp    = 1'b0;
        do_start      = 1'b0;
        do_finish     = 1'b0;
        do_clock      = 1'b0;
        do_send       = 1'b0;
        st_idx        = CMD_GO_IDLE;
        st_arg        = '0;
        st_app        = 1'b0;
        fin_ok        = 1'b0;
        fin_err       = ERR_NONE;
        send_val      = IDLE_BYTE;
        fp_inc        = r_frame_pos + 3'd1;
        frame_byte    = '0;

        if (!i_req_type) begin
            n_frame_pos   = '0;
            n_wait        = '0;
            n_reset_tries = '0;
            n_op_tries    = '0;
            n_is_sd       = 1'b0;
            n_first       = 1'b1;
            n_app         = 1'b0;
            n_cmd         = CMD_GO_IDLE;
            n_arg         = '0;
            n_crc         = '0;
            n_fast        = 1'b0;
            n_wake        = 5'd1;
            n_phase       = PH_WAKE;
            do_send       = 1'b1;
        end else begin
            case (r_phase)
                PH_IDLE: begin
                end
                PH_WAKE: begin
                    if (r_wake < WAKE_COUNT) begin
                        n_wake  = r_wake + 5'd1;
                        do_send = 1'b1;
                    end else begin
                        do_clock = 1'b1;
                    end
                end
                PH_CLOCK: begin
                    do_start = 1'b1;
                end
                PH_FRAME: begin
                    if (r_frame_pos < 3'd5) begin
                        case (fp_inc)
                            3'd1:    frame_byte = {2'b01, r_cmd};
                            3'd2:    frame_byte = r_arg[31:24];
                            3'd3:    frame_byte = r_arg[23:16];
                            3'd4:    frame_byte = r_arg[15:8];
                            default: frame_byte = r_arg[7:0];
                        endcase
                        n_frame_pos = fp_inc;
                        n_crc       = crc7_feed(r_crc, frame_byte);
                        do_send     = 1'b1;
                        send_val    = frame_byte;
                    end else if (r_frame_pos == 3'd5) begin
                        n_frame_pos = 3'd6;
                        do_send     = 1'b1;
                        send_val    = {r_crc, 1'b1};
                    end else begin
                        n_wait  = '0;
                        n_phase = PH_RESP;
                        do_send = 1'b1;
                    end
                end
                PH_RESP: begin
                    if (i_rx_byte == IDLE_BYTE && r_wait < RESP_POLLS) begin
                        n_wait  = r_wait + 8'd1;
                        do_send = 1'b1;
                    end else begin
                        case (r_cmd)
                            CMD_GO_IDLE: begin
                                if (r_reset_tries >= i_cfg.reset_limit) begin
                                    do_finish = 1'b1;
                                    fin_err   = ERR_RESET;
                                end else begin
                                    n_reset_tries = r_reset_tries + 6'd1;
                                    if (i_rx_byte == R1_IDLE) begin
                                        do_start = 1'b1;
                                        st_idx   = CMD_APP;
                                    end else begin
                                        do_clock = 1'b1;
                                    end
                                end
                            end
                            CMD_APP: begin
                                if (r_app) begin
                                    if (i_rx_byte[7] || i_rx_byte[2]) begin
                                        do_op_resp = 1'b1;
                                    end else begin
                                        do_start = 1'b1;
                                        st_idx   = CMD_SD_OP;
                                        st_arg   = r_first ? 32'd0 : HCS_ARG;
                                    end
                                end else if (i_rx_byte[7]) begin
                                    do_finish = 1'b1;
                                    fin_err   = ERR_PROBE;
                                end else begin
                                    n_is_sd    = ~i_rx_byte[2];
                                    n_op_tries = '0;
                                    n_first    = 1'b1;
                                    do_attempt = 1'b1;
                                end
                            end
                            CMD_SD_OP, CMD_SEND_OP: begin
                                do_op_resp = 1'b1;
                            end
                            CMD_SET_BLKLEN: begin
                                if (i_rx_byte != 8'd0) begin
                                    do_finish = 1'b1;
                                    fin_err   = ERR_BLKLEN;
                                end else begin
                                    do_start = 1'b1;
                                    st_idx   = CMD_CRC_OFF;
                                end
                            end
                            default: begin
                                do_finish = 1'b1;
                                if (i_rx_byte != 8'd0) begin
                                    fin_err = ERR_CRC_OFF;
                                end else begin
                                    fin_ok = 1'b1;
                                end
                            end
                        endcase
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end

        // Response to an op-cond attempt (direct or through the app prefix).
        if (do_op_resp) begin
            if (i_rx_byte[7]) begin
                do_finish = 1'b1;
                fin_err   = ERR_OP_COND;
            end else if (r_first) begin
                n_first    = 1'b0;
                do_attempt = 1'b1;
            end else if (!i_rx_byte[0]) begin
                do_start = 1'b1;
                st_idx   = CMD_SET_BLKLEN;
                st_arg   = {{(32-BLK_LEN_W){1'b0}}, i_cfg.block_length};
            end else begin
                do_attempt = 1'b1;
            end
        end

        // Next op-cond attempt, or give up when the limit is reached.
        if (do_attempt) begin
            if (n_op_tries >= i_cfg.op_limit) begin
                do_finish = 1'b1;
                fin_err   = ERR_OP_COND;
            end else begin
                n_op_tries = n_op_tries + 10'd1;
                do_start   = 1'b1;
                if (n_is_sd) begin
                    st_idx = CMD_APP;
                    st_app = 1'b1;
                end else begin
                    st_idx = CMD_SEND_OP;
                    st_arg = n_first ? 32'd0 : HCS_ARG;
                end
            end
        end

        if (do_start) begin
            n_cmd       = st_idx;
            n_arg       = st_arg;
            n_app       = st_app;
            n_frame_pos = '0;
            n_crc       = '0;
            n_phase     = PH_FRAME;
            do_send     = 1'b1;
            send_val    = IDLE_BYTE;
        end
        if (do_clock) begin
            n_phase = PH_CLOCK;
        end
        if (do_finish) begin
            n_phase = PH_IDLE;
            if (fin_ok) begin
                n_fast = 1'b1;
            end
        end

        n_res              = '0;
        n_res.tx_valid     = do_send;
        n_res.tx_byte      = do_send ? send_val : 8'd0;
        n_res.single_clock = do_clock;
        n_res.busy         = do_send || do_clock;
        n_res.done         = do_finish;
        n_res.init_ok      = do_finish && fin_ok;
        n_res.error_code   = do_finish ? fin_err : ERR_NONE;
        n_res.fast_clock   = n_fast;
        n_res.card_kind    = n_is_sd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_IDLE;
            r_frame_pos   <= '0;
            r_wait        <= '0;
            r_reset_tries <= '0;
            r_op_tries    <= '0;
            r_wake        <= '0;
            r_is_sd       <= 1'b0;
            r_first       <= 1'b1;
            r_app         <= 1'b0;
            r_cmd         <= CMD_GO_IDLE;
            r_arg         <= '0;
            r_crc         <= '0;
            r_fast        <= 1'b0;
            r_res         <= '0;
        end else if (i_advance) begin
            r_phase       <= n_phase;
            r_frame_pos   <= n_frame_pos;
            r_wait        <= n_wait;
            r_reset_tries <= n_reset_tries;
            r_op_tries    <= n_op_tries;
            r_wake        <= n_wake;
            r_is_sd       <= n_is_sd;
            r_first       <= n_first;
            r_app         <= n_app;
            r_cmd         <= n_cmd;
            r_arg         <= n_arg;
            r_crc         <= n_crc;
            r_fast        <= n_fast;
            r_res         <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

[src/sd_spi_card_init_sequencer_top.sv]
// The result of an accepted item is shown the cycle after it is taken.
// Throughput: one item per cycle. The sequencer's decode runs from the held state and the
// item straight into the result register, so a new item is taken whenever that register
// is empty or is being emptied in the same cycle.
// Reset (synchronous, active low): sequencer idle, slow clock, registers back to defaults.
module sd_spi_card_init_sequencer_top #(
    // Polls after a frame before a response is declared missing, and wake bytes sent.
    parameter logic [7:0] RESP_POLLS = sdi_pkg::RESP_WAIT_BYTES,
    parameter logic [4:0] WAKE_COUNT = sdi_pkg::WAKE_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Input item channel.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_req_type,
    input  logic [7:0]                    i_rx_byte,
    // Result item channel.
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_tx_valid,
    output logic [7:0]                    o_tx_byte,
    output logic                          o_single_clock,
    output logic                          o_fast_clock,
    output logic                          o_busy_res,
    output logic                          o_done_res,
    output logic                          o_init_ok,
    output logic                          o_card_kind,
    output logic [2:0]                    o_error_code,
    // Configuration write port.
    input  logic                          i_cfg_we,
    input  logic [sdi_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [sdi_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import sdi_pkg::*;

    t_cfg    r_cfg;
    t_result res;
    logic    r_out_valid;
    logic    accept;

    // The result register is the only buffer. It may be refilled in the same
    // cycle that the downstream side takes the item it currently holds.
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign accept     = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Configuration registers. The user must make writes arrive only while the sequencer is
    // quiet; the block does not enforce this or order them against items. Unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_length <= BLK_LEN_RESET;
            r_cfg.op_limit     <= OP_LIMIT_RESET;
            r_cfg.reset_limit  <= RST_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_BLOCK_LENGTH: r_cfg.block_length <= i_cfg_data[BLK_LEN_W-1:0];
                CFG_OP_LIMIT:     r_cfg.op_limit     <= i_cfg_data[OP_LIM_W-1:0];
                CFG_RESET_LIMIT:  r_cfg.reset_limit  <= i_cfg_data[RST_LIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // The sequencer holds the card start-up state (wake bytes, command
    // framing with CRC7, response polling, retry counters) and advances it
    // by exactly one step for each accepted item.
    sdi_seq #(
        .RESP_POLLS (RESP_POLLS),
        .WAKE_COUNT (WAKE_COUNT)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_advance  (accept),
        .i_req_type (i_req_type),
        .i_rx_byte  (i_rx_byte),
        .i_cfg      (r_cfg),
        .o_res      (res)
    );

    assign o_out_valid    = r_out_valid;
    assign o_tx_valid     = res.tx_valid;
    assign o_tx_byte      = res.tx_byte;
    assign o_single_clock = res.single_clock;
    assign o_fast_clock   = res.fast_clock;
    assign o_busy_res     = res.busy;
    assign o_done_res     = res.done;
    assign o_init_ok      = res.init_ok;
    assign o_card_kind    = res.card_kind;
    assign o_error_code   = res.error_code;

endmodule

[src/sdi_checker.sv]
`include "assert_macros.svh"

module sdi_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_ready,
    input logic       i_req_type,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic       o_tx_valid,
    input logic [7:0] o_tx_byte,
    input logic       o_single_clock,
    input logic       o_fast_clock,
    input logic       o_busy_res,
    input logic       o_done_res,
    input logic       o_init_ok,
    input logic [2:0] o_error_code
);

    // A stalled result item stays on the port with its byte and done flag unchanged.
    `SDI_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_tx_byte) && $stable(o_done_res))

    // A start request always answers with the first wake byte.
    `SDI_ASSERT_NXT(a_start_wake, i_clk, i_rst_n, i_in_valid && o_in_ready && !i_req_type, o_out_valid && o_tx_valid && o_tx_byte == 8'hFF && o_busy_res && !o_fast_clock)

    // The ending result asks for no bus action.
    `SDI_ASSERT_IMP(a_done_quiet, i_clk, i_rst_n, o_out_valid && o_done_res, !o_busy_res && !o_tx_valid && !o_single_clock)

    // Success ends the sequence, clears the error and selects the fast clock.
    `SDI_ASSERT_IMP(a_ok_fast, i_clk, i_rst_n, o_out_valid && o_init_ok, o_done_res && o_fast_clock && o_error_code == 3'd0)

    // A lone clock never comes with a byte exchange.
    `SDI_ASSERT_IMP(a_clock_alone, i_clk, i_rst_n, o_out_valid && o_single_clock, !o_tx_valid && o_busy_res)

endmodule

bind sd_spi_card_init_sequencer_top sdi_checker u_sdi_checker (.*);
